// ===== rtl/core/hrhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhc_pkg
// Types, constants and character helpers for the HTTP response classifier.
// ----------------------------------------------------------------------------
package hrhc_pkg;

  localparam int unsigned HEADER_LIMIT_MAX_DEF = 4096;
  localparam int unsigned TYPE_CHARS_DEF       = 8;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 64;

  localparam logic [1:0] REG_EXP_LEN  = 2'd0;
  localparam logic [1:0] REG_EXP_TYPE = 2'd1;
  localparam logic [1:0] REG_TYPE_LEN = 2'd2;
  localparam logic [1:0] REG_MAX_HDR  = 2'd3;

  localparam logic [3:0]  TYPE_LEN_RST = 4'd8;
  localparam logic [12:0] MAX_HDR_RST  = 13'd4096;

  localparam logic [3:0] LEN_KEY_LEN  = 4'd15;
  localparam logic [3:0] TYPE_KEY_LEN = 4'd13;
  localparam logic [3:0] STATUS_BYTES = 4'd12;

  localparam logic [9:0] CODE_OK    = 10'd200;
  localparam logic [9:0] CODE_AUTH  = 10'd407;
  localparam logic [9:0] CODE_TMO   = 10'd408;
  localparam logic [9:0] CODE_SERV  = 10'd500;

  typedef enum logic [1:0] {
    MODE_DATA  = 2'd0,
    MODE_CLOSE = 2'd1,
    MODE_TMO   = 2'd2,
    MODE_START = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    V_SUCCESS = 3'd0,
    V_AUTH    = 3'd1,
    V_FAKE    = 3'd2,
    V_NOTHTTP = 3'd3,
    V_HTTPERR = 3'd4,
    V_RETRY   = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_STATUS  = 2'd1,
    PH_HEADERS = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    FP_NONE  = 3'd0,
    FP_COLON = 3'd1,
    FP_VALUE = 3'd2,
    FP_TAIL  = 3'd3,
    FP_READY = 3'd4
  } field_t;

  localparam logic [2:0] BL_FOUND = 3'd5;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == 8'h0D) || (c == 8'h0A);
  endfunction

  // "content-length:" in lower case
  function automatic logic [7:0] len_key(input logic [3:0] pos);
    logic [7:0] k;
    unique case (pos)
      4'd0:  k = "c";
      4'd1:  k = "o";
      4'd2:  k = "n";
      4'd3:  k = "t";
      4'd4:  k = "e";
      4'd5:  k = "n";
      4'd6:  k = "t";
      4'd7:  k = "-";
      4'd8:  k = "l";
      4'd9:  k = "e";
      4'd10: k = "n";
      4'd11: k = "g";
      4'd12: k = "t";
      4'd13: k = "h";
      4'd14: k = ":";
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  // "content-type:" in lower case
  function automatic logic [7:0] type_key(input logic [3:0] pos);
    logic [7:0] k;
    unique case (pos)
      4'd0:  k = "c";
      4'd1:  k = "o";
      4'd2:  k = "n";
      4'd3:  k = "t";
      4'd4:  k = "e";
      4'd5:  k = "n";
      4'd6:  k = "t";
      4'd7:  k = "-";
      4'd8:  k = "t";
      4'd9:  k = "y";
      4'd10: k = "p";
      4'd11: k = "e";
      4'd12: k = ":";
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/http_response_header_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_header_classifier_unit
// Per-byte HTTP response status and header classifier, one verdict per
// response.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_      slave      tuser[1:0] mode, tdata[7:0] data_byte
// out_     master     tdata[2:0] verdict, tdata[12:3] status_code
// cfg_     APB        expected_length, expected_type, type_length, max_hdr
//
// One transaction per cycle while in_tready is high; a result is registered and
// appears in the cycle after the accepted input transaction that decides it.
// in_tready drops only while a result waits on a stalled out_tready.
// Synchronous active-low reset: idle phase, registers at defaults.
// ----------------------------------------------------------------------------
module http_response_header_classifier_unit #(
  parameter int unsigned HEADER_LIMIT_MAX = hrhc_pkg::HEADER_LIMIT_MAX_DEF,
  parameter int unsigned TYPE_CHARS       = hrhc_pkg::TYPE_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic [1:0]                  in_tuser,   // [1:0] mode
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [2:0] verdict, [12:3] status_code
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hrhc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [hrhc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [hrhc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import hrhc_pkg::*;

  localparam int unsigned BCW = $clog2(HEADER_LIMIT_MAX + 1);
  localparam int unsigned CW  = (BCW > 13) ? BCW : 13;
  localparam int unsigned TIW = $clog2(TYPE_CHARS + 1);

  // configuration
  logic [31:0] exp_len_r;
  logic [63:0] exp_type_r;
  logic [3:0]  type_len_r;
  logic [12:0] max_hdr_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r  <= '0;
      exp_type_r <= '0;
      type_len_r <= TYPE_LEN_RST;
      max_hdr_r  <= MAX_HDR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:3])
        REG_EXP_LEN:  exp_len_r  <= cfg_pwdata[31:0];
        REG_EXP_TYPE: exp_type_r <= cfg_pwdata;
        REG_TYPE_LEN: type_len_r <= cfg_pwdata[3:0];
        REG_MAX_HDR:  max_hdr_r  <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:3])
      REG_EXP_LEN:  cfg_prdata = {32'd0, exp_len_r};
      REG_EXP_TYPE: cfg_prdata = exp_type_r;
      REG_TYPE_LEN: cfg_prdata = {60'd0, type_len_r};
      REG_MAX_HDR:  cfg_prdata = {51'd0, max_hdr_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // effective compare count and header limit
  logic [3:0]    type_cnt;
  logic [3:0]    type_n;
  logic          zero_seen;
  logic [CW-1:0] limit;

  always_comb begin
    type_n    = (type_len_r > 4'(TYPE_CHARS)) ? 4'(TYPE_CHARS) : type_len_r;
    type_cnt  = type_n;
    zero_seen = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < type_n && !zero_seen && exp_type_r[8*k +: 8] == 8'h00) begin
        type_cnt  = 4'(k);
        zero_seen = 1'b1;
      end
    end
    limit = (CW'(max_hdr_r) > CW'(HEADER_LIMIT_MAX)) ? CW'(HEADER_LIMIT_MAX)
                                                     : CW'(max_hdr_r);
  end

  // response state
  phase_t           phase_r,    phase_nxt;
  logic [BCW-1:0]   bc_r,       bc_nxt;
  logic [9:0]       sv_r,       sv_nxt;
  logic             sok_r,      sok_nxt;
  logic [3:0]       lpos_r,     lpos_nxt;
  field_t           lph_r,      lph_nxt;
  logic [31:0]      lval_r,     lval_nxt;
  logic [3:0]       tpos_r,     tpos_nxt;
  field_t           tph_r,      tph_nxt;
  logic [TIW-1:0]   tidx_r,     tidx_nxt;
  logic             teq_r,      teq_nxt;
  logic [2:0]       bl_r,       bl_nxt;

  logic             out_valid_r;
  logic [15:0]      out_data_r;
  logic             emit;
  verdict_t         vd;
  logic [9:0]       code;

  logic             in_acc;
  logic [7:0]       c, lc;
  logic [1:0]       mode;
  logic [35:0]      lmul;
  logic [3:0]       tidx_ext;
  logic             pending;

  assign in_tready  = ~out_valid_r | out_tready;
  assign in_acc     = in_tvalid & in_tready;
  assign c          = in_tdata;
  assign lc         = to_lower(in_tdata);
  assign mode       = in_tuser;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    sv_nxt    = sv_r;
    sok_nxt   = sok_r;
    lpos_nxt  = lpos_r;
    lph_nxt   = lph_r;
    lval_nxt  = lval_r;
    tpos_nxt  = tpos_r;
    tph_nxt   = tph_r;
    tidx_nxt  = tidx_r;
    teq_nxt   = teq_r;
    bl_nxt    = bl_r;
    emit      = 1'b0;
    vd        = V_FAKE;
    code      = sv_r;
    lmul      = ({4'd0, lval_r} << 3) + ({4'd0, lval_r} << 1) + 36'(c - 8'h30);
    tidx_ext  = 4'(tidx_r);
    pending   = (phase_r == PH_STATUS) || (phase_r == PH_HEADERS);

    if (mode == MODE_START) begin
      phase_nxt = PH_STATUS;
      bc_nxt    = '0;
      sv_nxt    = '0;
      sok_nxt   = 1'b1;
      lpos_nxt  = '0;
      lph_nxt   = FP_NONE;
      lval_nxt  = '0;
      tpos_nxt  = '0;
      tph_nxt   = FP_NONE;
      tidx_nxt  = '0;
      teq_nxt   = 1'b1;
      bl_nxt    = '0;
    end else if (pending && mode != MODE_DATA) begin
      emit = 1'b1;
      vd   = V_RETRY;
      code = (phase_r == PH_HEADERS) ? sv_r : 10'd0;
    end else if (pending) begin
      if (bc_r < BCW'(HEADER_LIMIT_MAX)) bc_nxt = bc_r + 1'b1;

      // status line
      if (phase_r == PH_STATUS) begin
        if ((bc_r == BCW'(0) && c != "H") || (bc_r == BCW'(1) && c != "T") ||
            (bc_r == BCW'(2) && c != "T") || (bc_r == BCW'(3) && c != "P") ||
            (bc_r == BCW'(8) && c != " ") ||
            (bc_r == BCW'(9) && (c < "1" || c > "5")) ||
            ((bc_r == BCW'(10) || bc_r == BCW'(11)) && (c < "0" || c > "9")))
          sok_nxt = 1'b0;
        else if (bc_r >= BCW'(9) && bc_r <= BCW'(11))
          sv_nxt = (sv_r << 3) + (sv_r << 1) + 10'(c - 8'h30);
      end

      // length field
      if (lph_r == FP_NONE) begin
        if (lc == len_key(lpos_r))    lpos_nxt = lpos_r + 1'b1;
        else if (lc == len_key(4'd0)) lpos_nxt = 4'd1;
        else                          lpos_nxt = 4'd0;
        if (lpos_nxt == LEN_KEY_LEN) begin
          lpos_nxt = '0;
          lph_nxt  = FP_COLON;
        end
      end else if (lph_r != FP_READY) begin
        if (lph_r == FP_COLON && c == " ") begin
          lph_nxt = FP_VALUE;
        end else if (is_eol(c)) begin
          lph_nxt = FP_READY;
        end else if (lph_r == FP_VALUE || lph_r == FP_COLON) begin
          lph_nxt = FP_VALUE;
          if (c >= "0" && c <= "9")
            lval_nxt = (|lmul[35:32]) ? 32'hFFFF_FFFF : lmul[31:0];
          else
            lph_nxt = FP_TAIL;
        end
      end

      // type field
      if (tph_r == FP_NONE) begin
        if (lc == type_key(tpos_r))    tpos_nxt = tpos_r + 1'b1;
        else if (lc == type_key(4'd0)) tpos_nxt = 4'd1;
        else                           tpos_nxt = 4'd0;
        if (tpos_nxt == TYPE_KEY_LEN) begin
          tpos_nxt = '0;
          tph_nxt  = FP_COLON;
        end
      end else if (tph_r != FP_READY) begin
        tph_nxt = FP_VALUE;
        if (!(tph_r == FP_COLON && c == " ")) begin
          if (tidx_r < TIW'(TYPE_CHARS)) begin
            if (tidx_ext < type_cnt &&
                lc != to_lower(exp_type_r[8*tidx_ext[2:0] +: 8]))
              teq_nxt = 1'b0;
            tidx_nxt = tidx_r + 1'b1;
          end
          if (is_eol(c)) tph_nxt = FP_READY;
        end
      end

      // blank line
      if (bl_r != BL_FOUND) begin
        if (c == 8'h0D)      bl_nxt = (bl_r == 3'd2) ? 3'd4 : 3'd1;
        else if (c == 8'h0A) bl_nxt = (bl_r == 3'd1) ? 3'd2 :
                                      (bl_r == 3'd0) ? 3'd3 : BL_FOUND;
        else                 bl_nxt = 3'd0;
      end

      // decision
      code = sv_nxt;
      if (phase_r == PH_STATUS && bc_nxt >= BCW'(STATUS_BYTES)) begin
        if (!sok_nxt) begin
          emit = 1'b1; vd = V_NOTHTTP; code = 10'd0;
        end else if (sv_nxt == CODE_AUTH) begin
          emit = 1'b1; vd = V_AUTH;
        end else if (sv_nxt >= CODE_SERV || sv_nxt == CODE_TMO) begin
          emit = 1'b1; vd = V_RETRY;
        end else if (sv_nxt != CODE_OK) begin
          emit = 1'b1; vd = V_HTTPERR;
        end else begin
          phase_nxt = PH_HEADERS;
        end
      end
      if (!emit && phase_nxt == PH_HEADERS) begin
        priority if (lph_nxt == FP_READY && lval_nxt != exp_len_r) begin
          emit = 1'b1; vd = V_FAKE;
        end else if (lph_nxt == FP_READY && tph_nxt == FP_READY) begin
          emit = 1'b1;
          vd   = (teq_nxt && 4'(tidx_nxt) >= type_cnt) ? V_SUCCESS : V_FAKE;
        end else if (CW'(bc_nxt) >= limit || bl_nxt == BL_FOUND) begin
          emit = 1'b1; vd = V_FAKE;
        end else begin
          emit = 1'b0;
        end
      end
    end
    if (emit) phase_nxt = PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bc_r        <= '0;
      sv_r        <= '0;
      sok_r       <= 1'b1;
      lpos_r      <= '0;
      lph_r       <= FP_NONE;
      lval_r      <= '0;
      tpos_r      <= '0;
      tph_r       <= FP_NONE;
      tidx_r      <= '0;
      teq_r       <= 1'b1;
      bl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        bc_r    <= bc_nxt;
        sv_r    <= sv_nxt;
        sok_r   <= sok_nxt;
        lpos_r  <= lpos_nxt;
        lph_r   <= lph_nxt;
        lval_r  <= lval_nxt;
        tpos_r  <= tpos_nxt;
        tph_r   <= tph_nxt;
        tidx_r  <= tidx_nxt;
        teq_r   <= teq_nxt;
        bl_r    <= bl_nxt;
      end
      if (in_acc && emit)  out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) out_data_r <= {3'd0, code, vd};
  end

endmodule

// ===== rtl/core/hrhc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhc_checker
// Port-level checks for the HTTP response classifier.
// ----------------------------------------------------------------------------
module hrhc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  import hrhc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd6 && out_tdata[2:0] != 3'd7)
    else $error("verdict out of range");

  a_nothttp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == V_NOTHTTP |-> out_tdata[12:3] == 10'd0)
    else $error("non-HTTP verdict with a status code");

endmodule

bind http_response_header_classifier_unit hrhc_checker u_hrhc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
